// ===== hdl/lctc_pkg.sv =====
// Shared types, constants and tables of the lamp control with tilt cutoff block.
package lctc_pkg;

    // Default depth of the pot moving average
    localparam int AVG_DEPTH_DEF = 10;

    // Beam mapping limits
    localparam int LOW_LIMIT  = 1900;
    localparam int HIGH_START = 2500;
    localparam int POT_FULL   = 4095;
    localparam int DUTY_FULL  = 255;
    localparam int HIGH_SPAN  = POT_FULL - HIGH_START;

    // Reciprocals for dividing the scaled beam value (numerator below 2^19)
    localparam int BEAM_NUM_W   = 19;
    localparam int BEAM_SHIFT   = 31;
    localparam int BEAM_RECIP_W = 21;
    localparam logic [BEAM_RECIP_W-1:0] BEAM_RECIP_LOW =
        BEAM_RECIP_W'((64'd1 << BEAM_SHIFT) / LOW_LIMIT + 1);
    localparam logic [BEAM_RECIP_W-1:0] BEAM_RECIP_HIGH =
        BEAM_RECIP_W'((64'd1 << BEAM_SHIFT) / HIGH_SPAN + 1);

    // Configuration reset values
    localparam logic [13:0] THRESHOLD_RST = 14'd700;
    localparam logic [15:0] DWELL_RST     = 16'd1000;

    // Strip effect codes
    localparam logic [5:0] EFFECT_TABLE [16] = '{
        6'd12, 6'd11, 6'd2,  6'd7,  6'd0,  6'd1,  6'd3,  6'd5,
        6'd8,  6'd13, 6'd17, 6'd18, 6'd20, 6'd27, 6'd33, 6'd39
    };

    // Request kinds
    typedef enum logic [1:0] {
        KIND_POT   = 2'd0,
        KIND_ACCEL = 2'd1,
        KIND_SHORT = 2'd2,
        KIND_LONG  = 2'd3
    } t_kind;

    // Register indexes
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_DWELL     = 2'd1,
        REG_SHUTDOWN  = 2'd2,
        REG_STARTUP   = 2'd3
    } t_reg_idx;

    // What a request does to the beam duties
    typedef enum logic [1:0] {
        DOP_KEEP = 2'd0,
        DOP_DARK = 2'd1,
        DOP_SET  = 2'd2
    } t_duty_op;

    // Beam mapping region
    typedef enum logic [1:0] {
        BS_LOW  = 2'd0,
        BS_NONE = 2'd1,
        BS_HIGH = 2'd2,
        BS_FULL = 2'd3
    } t_beam_sel;

    typedef struct packed {
        logic [13:0] threshold;
        logic [15:0] dwell;
        logic        shutdown;
        logic        startup;
    } t_cfg;

    typedef struct packed {
        t_duty_op    op;
        logic [15:0] sum;
        logic        lamp_on;
        logic        tilt_off;
        logic [5:0]  effect;
    } t_job;

endpackage

// ===== hdl/lctc_ring_mem.sv =====
// Pot sample ring memory with per-entry valid bits and write-to-read bypass.
module lctc_ring_mem #(
    parameter int DEPTH = lctc_pkg::AVG_DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [11:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [11:0]   o_rdata
);
    import lctc_pkg::*;

    logic [11:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [11:0]    r_rd_q;
    logic           r_rd_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits and registered read, same-cycle write forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_we && (i_waddr == i_raddr)) begin
                r_rd_valid <= 1'b1;
            end else begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rd_q <= i_wdata;
        end else begin
            r_rd_q <= r_mem[i_raddr];
        end
    end

    // Entries never written read as zero
    assign o_rdata = r_rd_valid ? r_rd_q : 12'd0;

endmodule

// ===== hdl/lctc_ctrl.sv =====
// Request decode and lamp state update: on/tilt flags, ring sum, effect step.
module lctc_ctrl #(
    parameter int AVERAGE_DEPTH = lctc_pkg::AVG_DEPTH_DEF,
    parameter int AW            = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic [11:0]        i_pot_sample,
    input  logic signed [14:0] i_accel_x,
    input  logic signed [14:0] i_accel_y,
    input  logic signed [14:0] i_accel_z,
    input  logic [31:0]        i_time_ms,
    input  lctc_pkg::t_cfg     i_cfg,
    input  logic [11:0]        i_rd_data,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [11:0]        o_wdata,
    output logic [AW-1:0]      o_raddr,
    output lctc_pkg::t_job     o_job
);
    import lctc_pkg::*;

    logic          r_on, n_on;
    logic          r_tilt, n_tilt;
    logic          r_side_seen, n_side_seen;
    logic [31:0]   r_side_since, n_side_since;
    logic [AW-1:0] r_ring_slot, n_ring_slot;
    logic [15:0]   r_ring_sum, n_ring_sum;
    logic [3:0]    r_effect_slot, n_effect_slot;
    t_duty_op      op;

    logic [14:0]   mag_x, mag_y, mag_z;
    logic          active, side, dwell_done;
    logic [AW-1:0] slot_inc;

    function automatic logic [14:0] mag15(input logic signed [14:0] v);
        logic signed [14:0] neg;
        neg = -v;
        return v[14] ? $unsigned(neg) : $unsigned(v);
    endfunction

    // Tilt detection
    assign mag_x      = mag15(i_accel_x);
    assign mag_y      = mag15(i_accel_y);
    assign mag_z      = mag15(i_accel_z);
    assign side       = (mag_z < {1'b0, i_cfg.threshold}) &&
                        ((mag_x > {1'b0, i_cfg.threshold}) ||
                         (mag_y > {1'b0, i_cfg.threshold}));
    assign dwell_done = (32'(i_time_ms - r_side_since) >= {16'd0, i_cfg.dwell});
    assign active     = r_on && !r_tilt;
    assign slot_inc   = (r_ring_slot == AW'(AVERAGE_DEPTH - 1)) ? '0 : r_ring_slot + 1'b1;

    // Next state per request kind
    always_comb begin
        n_on          = r_on;
        n_tilt        = r_tilt;
        n_side_seen   = r_side_seen;
        n_side_since  = r_side_since;
        n_ring_slot   = r_ring_slot;
        n_ring_sum    = r_ring_sum;
        n_effect_slot = r_effect_slot;
        op            = DOP_KEEP;
        o_we          = 1'b0;
        if (i_accept) begin
            case (t_kind'(i_kind))
                KIND_POT: begin
                    if (active) begin
                        n_ring_sum  = r_ring_sum - {4'd0, i_rd_data} + {4'd0, i_pot_sample};
                        o_we        = 1'b1;
                        n_ring_slot = slot_inc;
                        op          = DOP_SET;
                    end
                end
                KIND_ACCEL: begin
                    if (i_cfg.shutdown) begin
                        if (side) begin
                            if (!r_side_seen) begin
                                n_side_seen  = 1'b1;
                                n_side_since = i_time_ms;
                            end else if (dwell_done && !r_tilt) begin
                                n_tilt = 1'b1;
                                n_on   = 1'b0;
                                op     = DOP_DARK;
                            end
                        end else begin
                            n_side_seen  = 1'b0;
                            n_side_since = i_time_ms;
                            if (r_tilt) begin
                                n_tilt = 1'b0;
                                if (!r_on && i_cfg.startup) begin
                                    n_on = 1'b1;
                                    op   = DOP_SET;
                                end
                            end
                        end
                    end
                end
                KIND_SHORT: begin
                    if (active) begin
                        n_effect_slot = r_effect_slot + 4'd1;
                    end
                end
                KIND_LONG: begin
                    if (!r_on) begin
                        n_on = 1'b1;
                        if (!r_tilt) begin
                            op = DOP_SET;
                        end
                    end else begin
                        n_on = 1'b0;
                        op   = DOP_DARK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Ring memory access: write current slot, prefetch next slot
    assign o_waddr = r_ring_slot;
    assign o_wdata = i_pot_sample;
    assign o_raddr = n_ring_slot;

    // Job handed to the beam pipeline
    assign o_job.op       = op;
    assign o_job.sum      = n_ring_sum;
    assign o_job.lamp_on  = n_on;
    assign o_job.tilt_off = n_tilt;
    assign o_job.effect   = EFFECT_TABLE[n_effect_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on          <= 1'b0;
            r_tilt        <= 1'b0;
            r_side_seen   <= 1'b0;
            r_side_since  <= '0;
            r_ring_slot   <= '0;
            r_ring_sum    <= '0;
            r_effect_slot <= '0;
        end else begin
            r_on          <= n_on;
            r_tilt        <= n_tilt;
            r_side_seen   <= n_side_seen;
            r_side_since  <= n_side_since;
            r_ring_slot   <= n_ring_slot;
            r_ring_sum    <= n_ring_sum;
            r_effect_slot <= n_effect_slot;
        end
    end

    // Slot stays inside the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_slot <= AW'(AVERAGE_DEPTH - 1))
        else $error("ring slot out of range");

    // Tilt shutdown always turns the lamp off
    a_tilt_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_tilt) |-> !r_on)
        else $error("tilt shutdown left lamp on");

    // Lamp state only changes on an accepted request
    a_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_on != $past(r_on)) |-> $past(i_accept))
        else $error("lamp state changed without a request");

endmodule

// ===== hdl/lctc_beam.sv =====
// Beam mapping pipeline: average, scaling, reciprocal divide, duty and output register.
module lctc_beam #(
    parameter int AVERAGE_DEPTH = lctc_pkg::AVG_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  lctc_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_low_beam_pwm,
    output logic [7:0]     o_high_beam_pwm,
    output logic           o_lamp_on,
    output logic           o_tilt_off,
    output logic [5:0]     o_strip_effect
);
    import lctc_pkg::*;

    // Average by reciprocal multiply, exact for 16-bit sums and depth up to 16
    localparam int AVG_SHIFT   = 21;
    localparam int AVG_RECIP_W = 22;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'((64'd1 << AVG_SHIFT) / AVERAGE_DEPTH + 1);

    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;

    t_job r_j1, r_j2, r_j3, r_j4;
    logic [15:0]           r_a2;
    logic [BEAM_NUM_W-1:0] r_n3;
    t_beam_sel             r_sel3, r_sel4;
    logic [7:0]            r_q4;
    logic [7:0]            r_low_duty, r_high_duty;
    logic [7:0]            n_low_duty, n_high_duty;

    logic [15+AVG_RECIP_W:0]            avg_prod;
    logic [15:0]                        avg;
    logic [15:0]                        hi_diff;
    logic [BEAM_NUM_W-1:0]              n_num;
    t_beam_sel                          n_sel;
    logic [BEAM_RECIP_W-1:0]            recip;
    logic [BEAM_NUM_W+BEAM_RECIP_W-1:0] beam_prod;
    logic [7:0]                         map_low, map_high;

    // Stage advance chain
    assign rdy_out = !r_vo || !i_out_stall;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_vo        <= 1'b0;
            r_low_duty  <= '0;
            r_high_duty <= '0;
        end else begin
            if (rdy1)    r_v1 <= i_load;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
            if (rdy4)    r_v4 <= r_v3;
            if (rdy_out) r_vo <= r_v4;
            if (rdy_out && r_v4) begin
                r_low_duty  <= n_low_duty;
                r_high_duty <= n_high_duty;
            end
        end
    end

    // Stage 2: average of the ring sum
    assign avg_prod = r_j1.sum * AVG_RECIP;
    assign avg      = avg_prod[AVG_SHIFT +: 16];

    // Stage 3: pick region and scale by full duty
    assign hi_diff = r_a2 - 16'(HIGH_START);
    always_comb begin
        n_num = '0;
        if (r_a2 < 16'(LOW_LIMIT)) begin
            n_sel = BS_LOW;
            n_num = ({3'd0, r_a2} << 8) - {3'd0, r_a2};
        end else if (r_a2 < 16'(HIGH_START)) begin
            n_sel = BS_NONE;
        end else if (hi_diff >= 16'(HIGH_SPAN)) begin
            n_sel = BS_FULL;
        end else begin
            n_sel = BS_HIGH;
            n_num = ({3'd0, hi_diff} << 8) - {3'd0, hi_diff};
        end
    end

    // Stage 4: divide by the region span
    assign recip     = (r_sel3 == BS_LOW) ? BEAM_RECIP_LOW : BEAM_RECIP_HIGH;
    assign beam_prod = r_n3 * recip;

    // Output: duties from the mapped region or from the op
    always_comb begin
        case (r_sel4)
            BS_LOW: begin
                map_low  = 8'(DUTY_FULL) - r_q4;
                map_high = '0;
            end
            BS_HIGH: begin
                map_low  = '0;
                map_high = r_q4;
            end
            BS_FULL: begin
                map_low  = '0;
                map_high = 8'(DUTY_FULL);
            end
            default: begin
                map_low  = '0;
                map_high = '0;
            end
        endcase
        case (r_j4.op)
            DOP_SET: begin
                n_low_duty  = map_low;
                n_high_duty = map_high;
            end
            DOP_DARK: begin
                n_low_duty  = '0;
                n_high_duty = '0;
            end
            default: begin
                n_low_duty  = r_low_duty;
                n_high_duty = r_high_duty;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_load) begin
            r_j1 <= i_job;
        end
        if (rdy2 && r_v1) begin
            r_j2 <= r_j1;
            r_a2 <= avg;
        end
        if (rdy3 && r_v2) begin
            r_j3   <= r_j2;
            r_n3   <= n_num;
            r_sel3 <= n_sel;
        end
        if (rdy4 && r_v3) begin
            r_j4   <= r_j3;
            r_sel4 <= r_sel3;
            r_q4   <= beam_prod[BEAM_SHIFT +: 8];
        end
        if (rdy_out && r_v4) begin
            o_low_beam_pwm  <= n_low_duty;
            o_high_beam_pwm <= n_high_duty;
            o_lamp_on       <= r_j4.lamp_on;
            o_tilt_off      <= r_j4.tilt_off;
            o_strip_effect  <= r_j4.effect;
        end
    end

    assign o_out_valid = r_vo;

    // Only one beam lit at a time
    a_one_beam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_low_beam_pwm == 8'd0) || (o_high_beam_pwm == 8'd0))
        else $error("both beams lit");

    // Lamp off means dark beams
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_lamp_on |-> (o_low_beam_pwm == 8'd0) && (o_high_beam_pwm == 8'd0))
        else $error("beam lit while lamp off");

    // Input stalls only when the first stage is full and blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rdy1 |-> r_v1 && r_v2 && r_v3 && r_v4 && r_vo && i_out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== hdl/lamp_control_with_tilt_cutoff_unit.sv =====
// Top level of the lamp control with tilt cutoff block: APB registers and pipeline.
// Throughput: one request per cycle while the result side does not stall; the next
// pot ring slot is prefetched by a registered read from a one-read, one-write memory
// and the beam mapping runs in a pipeline of average, scale, divide and output stages.
// Reset: synchronous, active low; clears lamp state, pipeline valids and the ring
// valid bits, and registers return to their defaults.
module lamp_control_with_tilt_cutoff_unit #(
    parameter int AVERAGE_DEPTH = lctc_pkg::AVG_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [11:0]        i_pot_sample,
    input  logic signed [14:0] i_accel_x,
    input  logic signed [14:0] i_accel_y,
    input  logic signed [14:0] i_accel_z,
    input  logic [31:0]        i_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_low_beam_pwm,
    output logic [7:0]         o_high_beam_pwm,
    output logic               o_lamp_on,
    output logic               o_tilt_off,
    output logic [5:0]         o_strip_effect,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lctc_pkg::*;

    localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

    t_cfg          r_cfg;
    logic          cfg_wr;
    t_reg_idx      reg_idx;
    logic          accept;
    logic          ready;
    t_job          job;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [11:0]   mem_wdata, mem_rdata;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.dwell     <= DWELL_RST;
            r_cfg.shutdown  <= 1'b1;
            r_cfg.startup   <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_THRESHOLD: r_cfg.threshold <= pwdata[13:0];
                REG_DWELL:     r_cfg.dwell     <= pwdata[15:0];
                REG_SHUTDOWN:  r_cfg.shutdown  <= pwdata[0];
                REG_STARTUP:   r_cfg.startup   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = {18'd0, r_cfg.threshold};
            REG_DWELL:     prdata = {16'd0, r_cfg.dwell};
            REG_SHUTDOWN:  prdata = {31'd0, r_cfg.shutdown};
            REG_STARTUP:   prdata = {31'd0, r_cfg.startup};
            default:       prdata = '0;
        endcase
    end

    // Request handshake
    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;

    lctc_ring_mem #(
        .DEPTH (AVERAGE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lctc_ctrl #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH),
        .AW            (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_pot_sample (i_pot_sample),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_time_ms    (i_time_ms),
        .i_cfg        (r_cfg),
        .i_rd_data    (mem_rdata),
        .o_we         (mem_we),
        .o_waddr      (mem_waddr),
        .o_wdata      (mem_wdata),
        .o_raddr      (mem_raddr),
        .o_job        (job)
    );

    lctc_beam #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_beam (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_job           (job),
        .o_ready         (ready),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_low_beam_pwm  (o_low_beam_pwm),
        .o_high_beam_pwm (o_high_beam_pwm),
        .o_lamp_on       (o_lamp_on),
        .o_tilt_off      (o_tilt_off),
        .o_strip_effect  (o_strip_effect)
    );

endmodule

// ===== tb/tb_lamp_control_with_tilt_cutoff_unit.sv =====
// Self-checking testbench for the lamp control with tilt cutoff unit.
module tb_lamp_control_with_tilt_cutoff_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lctc_pkg::*;

    localparam int AVG_DEPTH     = 10;
    localparam int BEAM_LOW_END  = 1900;
    localparam int BEAM_HI_START = 2500;
    localparam int POT_MAX       = 4095;
    localparam int DUTY_MAX      = 255;
    localparam int MG_MAX        = 16000;
    localparam int SETTLE_CYCLES = 8;

    // Strip effect codes, slot 0 in the low bits
    localparam logic [15:0][5:0] STRIP_CODES = {
        6'd39, 6'd33, 6'd27, 6'd20, 6'd18, 6'd17, 6'd13, 6'd8,
        6'd5,  6'd3,  6'd1,  6'd0,  6'd7,  6'd2,  6'd11, 6'd12
    };

    typedef struct packed {
        logic [7:0] low_pwm;
        logic [7:0] high_pwm;
        logic       lamp_on;
        logic       tilt_off;
        logic [5:0] effect;
    } t_lamp_status;

    // DUT ports
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_kind       = '0;
    logic [11:0]        i_pot_sample = '0;
    logic signed [14:0] i_accel_x    = '0;
    logic signed [14:0] i_accel_y    = '0;
    logic signed [14:0] i_accel_z    = '0;
    logic [31:0]        i_time_ms    = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [7:0]         o_low_beam_pwm;
    logic [7:0]         o_high_beam_pwm;
    logic               o_lamp_on;
    logic               o_tilt_off;
    logic [5:0]         o_strip_effect;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [3:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Register mirror
    logic [13:0] cfg_threshold = 14'd700;
    logic [15:0] cfg_dwell     = 16'd1000;
    logic        cfg_shutdown  = 1'b1;
    logic        cfg_startup   = 1'b1;

    // Lamp state mirror
    logic        on_m;
    logic        tilt_m;
    logic        side_seen_m;
    logic [31:0] side_since_m;
    logic [11:0] pot_ring_m [AVG_DEPTH];
    int          ring_slot_m;
    logic [15:0] ring_sum_m;
    logic [3:0]  effect_slot_m;
    logic [7:0]  low_duty_m;
    logic [7:0]  high_duty_m;

    t_lamp_status lamp_status_q [$];
    int           mismatches = 0;

    // Stimulus shaping
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int          rx_hold_cycles = 0;
    int          pot_run_left = 0;
    logic [11:0] pot_level = '0;
    int          tilt_run_left = 0;
    int          tilt_pose = 0;
    logic [31:0] clock_ms = 32'hFFFF_F000;

    lamp_control_with_tilt_cutoff_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("lamp_control_with_tilt_cutoff_unit: mismatch");
        $finish;
    end

    initial begin
        on_m = 1'b0;
        tilt_m = 1'b0;
        side_seen_m = 1'b0;
        side_since_m = '0;
        foreach (pot_ring_m[i]) pot_ring_m[i] = '0;
        ring_slot_m = 0;
        ring_sum_m = '0;
        effect_slot_m = '0;
        low_duty_m = '0;
        high_duty_m = '0;
    end

    // Beam duties from the pot average: low beam, dead zone, high beam
    function automatic void map_beams(int avg);
        int h;
        if (avg < BEAM_LOW_END) begin
            low_duty_m = 8'(DUTY_MAX - avg * DUTY_MAX / BEAM_LOW_END);
            high_duty_m = '0;
        end else if (avg < BEAM_HI_START) begin
            low_duty_m = '0;
            high_duty_m = '0;
        end else begin
            h = (avg - BEAM_HI_START) * DUTY_MAX / (POT_MAX - BEAM_HI_START);
            if (h > DUTY_MAX) h = DUTY_MAX;
            low_duty_m = '0;
            high_duty_m = 8'(h);
        end
    endfunction

    // Apply one request to the lamp mirror and return the status it leaves
    function automatic t_lamp_status lamp_step(t_kind k, logic [11:0] pot,
            logic signed [14:0] ax, logic signed [14:0] ay, logic signed [14:0] az,
            logic [31:0] now);
        int           mx, my, mz, thr;
        bit           sideways;
        logic [31:0]  elapsed;
        t_lamp_status r;
        case (k)
            KIND_POT: begin
                if (on_m && !tilt_m) begin
                    ring_sum_m = ring_sum_m - 16'(pot_ring_m[ring_slot_m]) + 16'(pot);
                    pot_ring_m[ring_slot_m] = pot;
                    ring_slot_m = (ring_slot_m == AVG_DEPTH - 1) ? 0 : ring_slot_m + 1;
                    map_beams(int'(ring_sum_m) / AVG_DEPTH);
                end
            end
            KIND_ACCEL: begin
                if (cfg_shutdown) begin
                    mx = (ax < 0) ? -int'(ax) : int'(ax);
                    my = (ay < 0) ? -int'(ay) : int'(ay);
                    mz = (az < 0) ? -int'(az) : int'(az);
                    thr = int'(cfg_threshold);
                    sideways = (mz < thr) && (mx > thr || my > thr);
                    elapsed = now - side_since_m;
                    if (sideways) begin
                        if (!side_seen_m) begin
                            side_seen_m = 1'b1;
                            side_since_m = now;
                        end else if (elapsed >= {16'd0, cfg_dwell} && !tilt_m) begin
                            tilt_m = 1'b1;
                            on_m = 1'b0;
                            low_duty_m = '0;
                            high_duty_m = '0;
                        end
                    end else begin
                        side_seen_m = 1'b0;
                        side_since_m = now;
                        if (tilt_m) begin
                            tilt_m = 1'b0;
                            // back to level: restore from the stored average
                            if (!on_m && cfg_startup) begin
                                on_m = 1'b1;
                                map_beams(int'(ring_sum_m) / AVG_DEPTH);
                            end
                        end
                    end
                end
            end
            KIND_SHORT: begin
                if (on_m && !tilt_m) effect_slot_m = effect_slot_m + 4'd1;
            end
            default: begin
                if (!on_m) begin
                    on_m = 1'b1;
                    if (!tilt_m) map_beams(int'(ring_sum_m) / AVG_DEPTH);
                end else begin
                    on_m = 1'b0;
                    low_duty_m = '0;
                    high_duty_m = '0;
                end
            end
        endcase
        r.low_pwm  = low_duty_m;
        r.high_pwm = high_duty_m;
        r.lamp_on  = on_m;
        r.tilt_off = tilt_m;
        r.effect   = STRIP_CODES[effect_slot_m];
        return r;
    endfunction

    function automatic logic [31:0] reg_mirror(logic [3:0] addr);
        case (t_reg_idx'(addr[3:2]))
            REG_THRESHOLD: return {18'd0, cfg_threshold};
            REG_DWELL:     return {16'd0, cfg_dwell};
            REG_SHUTDOWN:  return {31'd0, cfg_shutdown};
            default:       return {31'd0, cfg_startup};
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Scoreboard: predict on each accepted request, compare each accepted result
    always @(posedge i_clk) begin : scoreboard
        t_lamp_status want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (lamp_status_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending", $time);
                end else begin
                    want = lamp_status_q.pop_front();
                    check_field("low_beam_pwm", want.low_pwm, o_low_beam_pwm);
                    check_field("high_beam_pwm", want.high_pwm, o_high_beam_pwm);
                    check_field("lamp_on", want.lamp_on, o_lamp_on);
                    check_field("tilt_off", want.tilt_off, o_tilt_off);
                    check_field("strip_effect", want.effect, o_strip_effect);
                end
            end
            if (i_in_valid && !o_in_stall)
                lamp_status_q.push_back(lamp_step(t_kind'(i_kind), i_pot_sample,
                    i_accel_x, i_accel_y, i_accel_z, i_time_ms));
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_THRESHOLD: cfg_threshold = pwdata[13:0];
                        REG_DWELL:     cfg_dwell = pwdata[15:0];
                        REG_SHUTDOWN:  cfg_shutdown = pwdata[0];
                        default:       cfg_startup = pwdata[0];
                    endcase
                end else begin
                    check_field("register read", reg_mirror(paddr), prdata);
                end
            end
        end
    end

    // Result side: random stall before each result, plus an occasional long hold
    initial begin : result_taker
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            n = rx_quiet ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Offer one request after a random gap; returns at the edge that takes it
    task automatic send_request(t_kind k, logic [11:0] pot, logic signed [14:0] ax,
            logic signed [14:0] ay, logic signed [14:0] az, logic [31:0] stamp);
        int n;
        n = tx_quiet ? 0 : $urandom_range(0, 6);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_pot_sample <= pot;
        i_accel_x    <= ax;
        i_accel_y    <= ay;
        i_accel_z    <= az;
        i_time_ms    <= stamp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic apb_access(bit wr, t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 4'(4 * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering and let every pending result come out
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (lamp_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_lamp(int thr, int dwell, bit shut, bit start);
        drain_requests();
        apb_access(1'b1, REG_THRESHOLD, 32'(thr));
        apb_access(1'b1, REG_DWELL, 32'(dwell));
        apb_access(1'b1, REG_SHUTDOWN, {31'd0, shut});
        apb_access(1'b1, REG_STARTUP, {31'd0, start});
        for (int i = 0; i < 4; i++) apb_access(1'b0, t_reg_idx'(i), '0);
    endtask

    function automatic logic signed [14:0] signed_mg(int mag);
        return $urandom_range(0, 1) ? 15'(-mag) : 15'(mag);
    endfunction

    // Random request: pot runs at chosen levels, accel runs of one pose, button presses
    task automatic send_random_request();
        int                 roll;
        int                 thr;
        int                 big;
        t_kind              k;
        logic [11:0]        pot;
        logic signed [14:0] ax, ay, az;
        logic [31:0]        stamp;
        roll  = $urandom_range(0, 99);
        thr   = int'(cfg_threshold);
        pot   = 12'($urandom());
        ax    = signed_mg($urandom_range(0, MG_MAX));
        ay    = signed_mg($urandom_range(0, MG_MAX));
        az    = signed_mg($urandom_range(0, MG_MAX));
        stamp = $urandom();
        // a dark lamp that is not tilted is more likely to get a long press
        if (!on_m && !tilt_m && roll < 25) k = KIND_LONG;
        else if (roll < 45) k = KIND_POT;
        else if (roll < 80) k = KIND_ACCEL;
        else if (roll < 93) k = KIND_SHORT;
        else k = KIND_LONG;

        if (k == KIND_POT) begin
            if (pot_run_left == 0) begin
                pot_run_left = $urandom_range(1, 14);
                case ($urandom_range(0, 6))
                    0: pot_level = 12'd0;
                    1: pot_level = 12'd1899;
                    2: pot_level = 12'd1900;
                    3: pot_level = 12'd2499;
                    4: pot_level = 12'd2500;
                    5: pot_level = 12'd4095;
                    default: pot_level = 12'($urandom());
                endcase
            end
            pot_run_left--;
            if ($urandom_range(0, 3) != 0) pot = pot_level;
        end

        if (k == KIND_ACCEL) begin
            if (tilt_run_left == 0) begin
                tilt_run_left = $urandom_range(1, 8);
                tilt_pose = $urandom_range(0, 9);
            end
            tilt_run_left--;
            if (tilt_pose < 5) begin
                // sideways, with the odd value right at the threshold
                big = (thr >= MG_MAX) ? MG_MAX : $urandom_range(thr + 1, MG_MAX);
                if ($urandom_range(0, 7) == 0) big = thr;
                az = signed_mg((thr == 0) ? 0 : $urandom_range(0, thr - 1));
                if ($urandom_range(0, 7) == 0) az = signed_mg(thr);
                if ($urandom_range(0, 1)) ax = signed_mg(big);
                else ay = signed_mg(big);
            end else if (tilt_pose < 9) begin
                az = signed_mg($urandom_range(thr, MG_MAX));
            end
            // time stamps: small steps, dwell edges, longer steps, odd jumps
            roll = $urandom_range(0, 99);
            if (roll < 55) clock_ms += 32'($urandom_range(0, 400));
            else if (roll < 80 && side_seen_m)
                clock_ms = side_since_m + {16'd0, cfg_dwell} + 32'($urandom_range(0, 2)) - 32'd1;
            else if (roll < 95) clock_ms += 32'($urandom_range(0, 3000));
            else clock_ms = $urandom();
            stamp = clock_ms;
        end
        send_request(k, pot, ax, ay, az, stamp);
    endtask

    task automatic run_phase(int thr, int dwell, bit shut, bit start, int count, bit quiet);
        configure_lamp(thr, dwell, shut, start);
        tx_quiet = quiet;
        rx_quiet = quiet;
        repeat (count) send_random_request();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_register_defaults();
        for (int i = 0; i < 4; i++) apb_access(1'b0, t_reg_idx'(i), '0);
    endtask

    // Ignored requests while off, power on, full-scale pot, effect stepping
    task automatic test_power_and_effects();
        send_request(KIND_POT, 12'd4095, 0, 0, 0, 0);
        send_request(KIND_SHORT, 12'd0, 0, 0, 0, 0);
        send_request(KIND_ACCEL, 12'd0, 0, 0, 1000, 32'd0);
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
        repeat (10) send_request(KIND_POT, 12'd4095, 0, 0, 0, 0);
        send_request(KIND_SHORT, 12'd0, 0, 0, 0, 0);
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
    endtask

    // Dwell across the time wrap, long press while tilted, tilt cleared on level
    task automatic test_tilt_dwell();
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
        send_request(KIND_ACCEL, 12'd0, -16000, 0, 0, 32'hFFFF_FF00);
        send_request(KIND_ACCEL, 12'd0, 0, 16000, -699, 32'h0000_02E7);
        send_request(KIND_ACCEL, 12'd0, 0, -16000, 0, 32'h0000_02E8);
        send_request(KIND_POT, 12'd0, 0, 0, 0, 0);
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
        send_request(KIND_ACCEL, 12'd0, 0, 0, -16000, 32'h0000_0300);
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
        send_request(KIND_LONG, 12'd0, 0, 0, 0, 0);
        send_request(KIND_ACCEL, 12'd0, 16000, 0, 0, 32'h0000_1000);
        send_request(KIND_ACCEL, 12'd0, 701, 0, 700, 32'h0000_1200);
        send_request(KIND_ACCEL, 12'd0, 16000, 0, 0, 32'h0000_13E8);
        send_request(KIND_ACCEL, 12'd0, 0, 0, 16000, 32'h0000_1400);
    endtask

    task automatic test_config_sweep();
        run_phase(700, 1000, 1'b1, 1'b1, 240, 1'b0);
        run_phase(0, 0, 1'b1, 1'b1, 160, 1'b0);
        run_phase(1200, 65535, 1'b1, 1'b0, 220, 1'b0);
        run_phase(16000, 0, 1'b1, 1'b1, 120, 1'b1);
        run_phase(0, 65535, 1'b0, 1'b1, 160, 1'b0);
        run_phase($urandom_range(300, 3000), $urandom_range(0, 2500), 1'b1, 1'b1, 240, 1'b0);
        run_phase(900, 50, 1'b1, 1'b0, 160, 1'b0);
    endtask

    // Result side held off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        rx_hold_cycles = 120;
        repeat (60) send_random_request();
        tx_quiet = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_power_and_effects();
        test_tilt_dwell();
        test_config_sweep();
        test_backpressure();
        drain_requests();
        if (mismatches == 0)
            $display("lamp_control_with_tilt_cutoff_unit: match");
        else
            $display("lamp_control_with_tilt_cutoff_unit: mismatch");
        $finish;
    end

endmodule
